### rtl/core/lfu_page_replacement_core_assert.svh
// Assertion macros for the LFU page replacement core.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef LFU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication
`define LFU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU page replacement core.
// No dependencies.
`default_nettype none

package lfu_pkg;

  localparam int FRAMES      = 8;
  localparam int COUNT_BITS  = 16;
  localparam int PAGE_BITS   = 8;
  localparam int STAMP_BITS  = 32;
  localparam int TOTAL_BITS  = 32;
  localparam int CFG_BITS    = 4;
  localparam int OSLOT_BITS  = 3;
  localparam int SLOT_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NCNT_BITS   = $clog2(FRAMES + 1);
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } lfu_state_t;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } frame_ent_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_BITS-1:0]  addr;
    logic [PAGE_BITS-1:0]  page;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } frame_wr_t;

  typedef struct packed {
    logic match;
    logic empty;
    logic better;
  } scan_res_t;

endpackage

`default_nettype wire

### rtl/core/lfu_page_replacement_core.sv
// LFU page replacement core: sequencer, counters and result registers.
// Depends on lfu_pkg, lfu_frame_table, lfu_scan_unit and the assertion header.
`default_nettype none

`include "lfu_page_replacement_core_assert.svh"

// One page reference is taken when start is high and busy is low. The active
// frames are scanned one per cycle through a single compare unit, then the
// update state writes the table and registers the result, which shows on the
// out_ ports for exactly one cycle with out_valid. busy is low again in the
// cycle that carries the result, so a new item may be accepted there. Results
// cannot be stalled: the receiver must take out_valid when it comes. The frame
// count register is taken any time cfg_valid is high (cfg_ready is held high);
// it must only change while the core is idle.
module lfu_page_replacement_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lfu_pkg::PAGE_BITS-1:0]  in_page,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [lfu_pkg::OSLOT_BITS-1:0] out_frame_slot,
  output logic                           out_evicted_valid,
  output logic [lfu_pkg::PAGE_BITS-1:0]  out_evicted_page,
  output logic [lfu_pkg::TOTAL_BITS-1:0] out_hit_total,
  output logic [lfu_pkg::TOTAL_BITS-1:0] out_fault_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfu_pkg::CFG_BITS-1:0]   cfg_frames_in_use
);
  import lfu_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  lfu_state_t            state_r, state_nxt;
  logic [CFG_BITS-1:0]   frames_r;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [NCNT_BITS-1:0]  n_r, n_nxt;
  logic [SLOT_BITS-1:0]  idx_r, idx_nxt;

  logic                  found_r, found_nxt;
  logic [SLOT_BITS-1:0]  hit_slot_r, hit_slot_nxt;
  logic [COUNT_BITS-1:0] hit_count_r, hit_count_nxt;
  logic [STAMP_BITS-1:0] hit_stamp_r, hit_stamp_nxt;

  logic                  empty_r, empty_nxt;
  logic [SLOT_BITS-1:0]  empty_slot_r, empty_slot_nxt;

  logic [SLOT_BITS-1:0]  best_slot_r, best_slot_nxt;
  logic [COUNT_BITS-1:0] best_count_r, best_count_nxt;
  logic [STAMP_BITS-1:0] best_stamp_r, best_stamp_nxt;
  logic [PAGE_BITS-1:0]  best_page_r, best_page_nxt;

  logic [STAMP_BITS-1:0] stamp_cnt_r, stamp_cnt_nxt;
  logic [TOTAL_BITS-1:0] hit_tot_r, hit_tot_nxt;
  logic [TOTAL_BITS-1:0] fault_tot_r, fault_tot_nxt;

  logic                  ov_r, ov_nxt;
  logic                  ohit_r, ohit_nxt;
  logic [SLOT_BITS-1:0]  oslot_r, oslot_nxt;
  logic                  oev_r, oev_nxt;
  logic [PAGE_BITS-1:0]  oevp_r, oevp_nxt;

  logic [NCNT_BITS-1:0]  n_clamp;
  logic                  last_idx;
  logic [STAMP_BITS-1:0] stamp_inc;
  frame_ent_t            ent;
  frame_wr_t             wr;
  scan_res_t             res;

  lfu_frame_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r),
    .rd_ent  (ent),
    .wr      (wr)
  );

  lfu_scan_unit u_scan (
    .ent        (ent),
    .page       (page_r),
    .best_count (best_count_r),
    .best_stamp (best_stamp_r),
    .res        (res)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  // zero acts as one, anything above the table size as the table size
  always_comb begin
    if (frames_r == '0) begin
      n_clamp = NCNT_BITS'(1);
    end else if (32'(frames_r) > FRAMES) begin
      n_clamp = NCNT_BITS'(FRAMES);
    end else begin
      n_clamp = NCNT_BITS'(frames_r);
    end
  end

  assign last_idx  = (NCNT_BITS'(idx_r) + NCNT_BITS'(1)) == n_r;
  assign stamp_inc = (stamp_cnt_r == '1) ? stamp_cnt_r : stamp_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stamp_cnt_r <= '0;
      hit_tot_r   <= '0;
      fault_tot_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      hit_tot_r   <= hit_tot_nxt;
      fault_tot_r <= fault_tot_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_count_r  <= hit_count_nxt;
    hit_stamp_r  <= hit_stamp_nxt;
    empty_r      <= empty_nxt;
    empty_slot_r <= empty_slot_nxt;
    best_slot_r  <= best_slot_nxt;
    best_count_r <= best_count_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_page_r  <= best_page_nxt;
    ohit_r       <= ohit_nxt;
    oslot_r      <= oslot_nxt;
    oev_r        <= oev_nxt;
    oevp_r       <= oevp_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    hit_slot_nxt   = hit_slot_r;
    hit_count_nxt  = hit_count_r;
    hit_stamp_nxt  = hit_stamp_r;
    empty_nxt      = empty_r;
    empty_slot_nxt = empty_slot_r;
    best_slot_nxt  = best_slot_r;
    best_count_nxt = best_count_r;
    best_stamp_nxt = best_stamp_r;
    best_page_nxt  = best_page_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    hit_tot_nxt    = hit_tot_r;
    fault_tot_nxt  = fault_tot_r;
    ov_nxt         = 1'b0;
    ohit_nxt       = ohit_r;
    oslot_nxt      = oslot_r;
    oev_nxt        = oev_r;
    oevp_nxt       = oevp_r;
    wr             = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt  = in_page;
          n_nxt     = n_clamp;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          empty_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!found_r && res.match) begin
          found_nxt     = 1'b1;
          hit_slot_nxt  = idx_r;
          hit_count_nxt = ent.count;
          hit_stamp_nxt = ent.stamp;
        end
        if (!empty_r && res.empty) begin
          empty_nxt      = 1'b1;
          empty_slot_nxt = idx_r;
        end
        // frame 0 seeds the victim; only used when every active frame is valid
        if (idx_r == '0 || res.better) begin
          best_slot_nxt  = idx_r;
          best_count_nxt = ent.count;
          best_stamp_nxt = ent.stamp;
          best_page_nxt  = ent.page;
        end
        if (last_idx) begin
          state_nxt = ST_UPD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        wr.en    = 1'b1;
        wr.page  = page_r;
        ov_nxt   = 1'b1;
        ohit_nxt = found_r;
        if (found_r) begin
          wr.addr     = hit_slot_r;
          wr.count    = (hit_count_r == COUNT_MAX) ? hit_count_r : hit_count_r + 1'b1;
          wr.stamp    = hit_stamp_r;
          hit_tot_nxt = (hit_tot_r == '1) ? hit_tot_r : hit_tot_r + 1'b1;
          oslot_nxt   = hit_slot_r;
          oev_nxt     = 1'b0;
          oevp_nxt    = '0;
        end else begin
          wr.addr       = empty_r ? empty_slot_r : best_slot_r;
          wr.count      = COUNT_ONE;
          wr.stamp      = stamp_inc;
          stamp_cnt_nxt = stamp_inc;
          fault_tot_nxt = (fault_tot_r == '1) ? fault_tot_r : fault_tot_r + 1'b1;
          oslot_nxt     = empty_r ? empty_slot_r : best_slot_r;
          oev_nxt       = !empty_r;
          oevp_nxt      = empty_r ? '0 : best_page_r;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy              = state_r != ST_IDLE;
  assign out_valid         = ov_r;
  assign out_hit           = ohit_r;
  assign out_frame_slot    = OSLOT_BITS'(oslot_r);
  assign out_evicted_valid = oev_r;
  assign out_evicted_page  = oevp_r;
  assign out_hit_total     = hit_tot_r;
  assign out_fault_total   = fault_tot_r;

  `LFU_ASSERT_NEXT(a_accept_scans, start && !busy, state_r == ST_SCAN, "accept did not start scan")
  `LFU_ASSERT_NEXT(a_upd_strobes, state_r == ST_UPD, out_valid && !busy, "update gave no result")
  `LFU_ASSERT_IMPL(a_strobe_idle, out_valid,
                   state_r != ST_UPD && state_r != ST_SCAN, "result while busy")
  `LFU_ASSERT_IMPL(a_hit_no_evict, out_valid && out_hit, !out_evicted_valid, "eviction on hit")
  `LFU_ASSERT_NEXT(a_totals_move, state_r == ST_UPD,
                   (hit_tot_r != $past(hit_tot_r)) || (fault_tot_r != $past(fault_tot_r)) ||
                   (hit_tot_r == '1) || (fault_tot_r == '1), "totals did not advance")

endmodule

`default_nettype wire

### rtl/core/lfu_frame_table.sv
// Frame table: valid, page, use count and load stamp per frame.
// One read port at the scan index, one write port. Uses lfu_pkg.
`default_nettype none

module lfu_frame_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lfu_pkg::SLOT_BITS-1:0] rd_addr,
  output lfu_pkg::frame_ent_t           rd_ent,
  input  lfu_pkg::frame_wr_t            wr
);
  import lfu_pkg::*;

  logic [FRAMES-1:0]     valid_r;
  logic [PAGE_BITS-1:0]  page_r  [FRAMES];
  logic [COUNT_BITS-1:0] count_r [FRAMES];
  logic [STAMP_BITS-1:0] stamp_r [FRAMES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // contents carry no reset; an entry is read only once its valid bit is set
  always_ff @(posedge clk) begin
    if (wr.en) begin
      page_r[wr.addr]  <= wr.page;
      count_r[wr.addr] <= wr.count;
      stamp_r[wr.addr] <= wr.stamp;
    end
  end

  assign rd_ent.valid = valid_r[rd_addr];
  assign rd_ent.page  = page_r[rd_addr];
  assign rd_ent.count = count_r[rd_addr];
  assign rd_ent.stamp = stamp_r[rd_addr];

endmodule

`default_nettype wire

### rtl/core/lfu_scan_unit.sv
// Shared compare unit used once per scanned frame: page match, empty frame,
// and least-count / oldest-stamp ordering against the current victim. Uses lfu_pkg.
`default_nettype none

module lfu_scan_unit (
  input  lfu_pkg::frame_ent_t            ent,
  input  logic [lfu_pkg::PAGE_BITS-1:0]  page,
  input  logic [lfu_pkg::COUNT_BITS-1:0] best_count,
  input  logic [lfu_pkg::STAMP_BITS-1:0] best_stamp,
  output lfu_pkg::scan_res_t             res
);
  import lfu_pkg::*;

  logic cnt_lt;
  logic cnt_eq;
  logic stamp_lt;

  assign cnt_lt   = ent.count < best_count;
  assign cnt_eq   = ent.count == best_count;
  assign stamp_lt = ent.stamp < best_stamp;

  assign res.match  = ent.valid && (ent.page == page);
  assign res.empty  = !ent.valid;
  // strict: ties keep the lower index
  assign res.better = cnt_lt || (cnt_eq && stamp_lt);

endmodule

`default_nettype wire

### test/lfu_page_checker.sv
// Scoreboard for the LFU page replacement core: watches the reference, result
// and frame-count channels, predicts each result and compares it field by field.
// Depends on lfu_pkg.
`default_nettype none

module lfu_page_checker
  import lfu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic                  out_valid,
  input  logic                  out_hit,
  input  logic [OSLOT_BITS-1:0] out_frame_slot,
  input  logic                  out_evicted_valid,
  input  logic [PAGE_BITS-1:0]  out_evicted_page,
  input  logic [TOTAL_BITS-1:0] out_hit_total,
  input  logic [TOTAL_BITS-1:0] out_fault_total,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_frames_in_use,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic                  hit;
    logic [OSLOT_BITS-1:0] slot;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [TOTAL_BITS-1:0] hit_total;
    logic [TOTAL_BITS-1:0] fault_total;
  } page_result_t;

  // mirror of the frame table
  logic                  fr_valid [FRAMES];
  logic [PAGE_BITS-1:0]  fr_page  [FRAMES];
  logic [COUNT_BITS-1:0] fr_count [FRAMES];
  logic [STAMP_BITS-1:0] fr_stamp [FRAMES];
  logic [STAMP_BITS-1:0] stamp_ctr;
  logic [TOTAL_BITS-1:0] hit_ctr;
  logic [TOTAL_BITS-1:0] fault_ctr;
  logic [CFG_BITS-1:0]   frames_cfg;

  page_result_t expected_q[$];
  int           fails;
  int           nchk;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    fails      = 0;
    nchk       = 0;
  end

  function automatic page_result_t lfu_lookup(input logic [PAGE_BITS-1:0] pg);
    page_result_t r;
    int           n;
    int           slot;
    bit           found;
    bit           empty;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    // 0 behaves as one frame, anything above the table size as the full table
    if (frames_cfg == 0)
      n = 1;
    else if (frames_cfg > FRAMES)
      n = FRAMES;
    else
      n = frames_cfg;

    // lowest-index match wins when a page is resident twice
    for (int s = 0; s < n; s++)
      if (!found && fr_valid[s] && fr_page[s] == pg) begin
        found = 1'b1;
        slot  = s;
      end

    if (found) begin
      if (fr_count[slot] != '1)
        fr_count[slot] = fr_count[slot] + 1'b1;
      if (hit_ctr != '1)
        hit_ctr = hit_ctr + 1'b1;
    end else begin
      for (int s = 0; s < n; s++)
        if (!empty && !fr_valid[s]) begin
          empty = 1'b1;
          slot  = s;
        end
      if (!empty) begin
        slot = 0;
        for (int s = 1; s < n; s++)
          if (fr_count[s] < fr_count[slot] ||
              (fr_count[s] == fr_count[slot] && fr_stamp[s] < fr_stamp[slot]))
            slot = s;
        r.ev_valid = 1'b1;
        r.ev_page  = fr_page[slot];
      end
      if (stamp_ctr != '1)
        stamp_ctr = stamp_ctr + 1'b1;
      fr_valid[slot] = 1'b1;
      fr_page[slot]  = pg;
      fr_count[slot] = COUNT_BITS'(1);
      fr_stamp[slot] = stamp_ctr;
      if (fault_ctr != '1)
        fault_ctr = fault_ctr + 1'b1;
    end

    r.hit         = found;
    r.slot        = OSLOT_BITS'(slot);
    r.hit_total   = hit_ctr;
    r.fault_total = fault_ctr;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    page_result_t e;
    if (!rst_n) begin
      for (int s = 0; s < FRAMES; s++) begin
        fr_valid[s] = 1'b0;
        fr_page[s]  = '0;
        fr_count[s] = '0;
        fr_stamp[s] = '0;
      end
      stamp_ctr  = '0;
      hit_ctr    = '0;
      fault_ctr  = '0;
      frames_cfg = CFG_RESET;
      expected_q.delete();
    end else begin
      // compare before pushing: a result and a new item can share an edge
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no reference outstanding (page 0x%0h slot %0d)",
                 out_evicted_page, out_frame_slot);
          fails++;
        end else begin
          e = expected_q.pop_front();
          check_field("hit", e.hit, out_hit);
          check_field("frame_slot", e.slot, out_frame_slot);
          check_field("evicted_valid", e.ev_valid, out_evicted_valid);
          check_field("evicted_page", e.ev_page, out_evicted_page);
          check_field("hit_total", e.hit_total, out_hit_total);
          check_field("fault_total", e.fault_total, out_fault_total);
          nchk++;
        end
      end
      if (cfg_valid && cfg_ready)
        frames_cfg = cfg_frames_in_use;
      if (start && !busy)
        expected_q.push_back(lfu_lookup(in_page));
    end
    fail_count <= fails;
    pending    <= expected_q.size();
    checked    <= nchk;
  end

endmodule

`default_nettype wire

### test/tb_lfu_page_replacement_core.sv
// Testbench top for the LFU page replacement core: clock, reset, stimulus and verdict.
// Depends on lfu_pkg, lfu_page_replacement_core and lfu_page_checker.
`default_nettype none

module tb_lfu_page_replacement_core;
  import lfu_pkg::*;

  localparam int SOAK_HITS  = 40;
  localparam int RAND_ITEMS = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PAGE_BITS-1:0]  in_page = '0;
  logic                  out_valid;
  logic                  out_hit;
  logic [OSLOT_BITS-1:0] out_frame_slot;
  logic                  out_evicted_valid;
  logic [PAGE_BITS-1:0]  out_evicted_page;
  logic [TOTAL_BITS-1:0] out_hit_total;
  logic [TOTAL_BITS-1:0] out_fault_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_frames_in_use = '0;

  int fail_count;
  int pending;
  int checked;

  int                   n_items;
  int                   n_settings;
  int                   n_random;
  int                   phase_len;
  int                   burst_left;
  int                   ws_size;
  bit                   steady;
  logic [PAGE_BITS-1:0] ws [12];
  logic [PAGE_BITS-1:0] pg;
  logic [CFG_BITS-1:0]  fcount;

  lfu_page_replacement_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use)
  );

  lfu_page_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // hold start high until the core takes the item
  task automatic drive_ref(input logic [PAGE_BITS-1:0] p);
    start   <= 1'b1;
    in_page <= p;
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_frame_count(input logic [CFG_BITS-1:0] v);
    drain();
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    n_items    = 0;
    n_settings = 0;
    n_random   = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill all eight frames from empty, page extremes, two hits, then LRU-style ties
    drive_ref(8'h00);
    drive_ref(8'hFF);
    drive_ref(8'h00);
    drive_ref(8'h55);
    drive_ref(8'hAA);
    drive_ref(8'h01);
    drive_ref(8'h02);
    drive_ref(8'h03);
    drive_ref(8'h04);
    drive_ref(8'hFF);
    drive_ref(8'h09);
    drive_ref(8'h0A);

    // shrink to two frames so page 3 gets a second copy, then widen past the table
    set_frame_count(CFG_BITS'(2));
    drive_ref(8'h03);
    set_frame_count(CFG_BITS'(15));
    drive_ref(8'h03);
    set_frame_count(CFG_BITS'(0));
    drive_ref(8'hC8);
    set_frame_count(CFG_BITS'(1));
    drive_ref(8'hC8);

    // heavy reuse: one frame hit many times, then a lightly used neighbor
    // must be the one replaced
    set_frame_count(CFG_BITS'(2));
    drive_ref(8'h64);
    repeat (SOAK_HITS) drive_ref(8'h64);
    drive_ref(8'h65);
    drive_ref(8'h66);

    // random phases: each with its own frame count and working set of pages
    while (n_random < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       fcount = CFG_BITS'(0);
        1:       fcount = CFG_BITS'(1);
        2:       fcount = CFG_BITS'(FRAMES);
        3:       fcount = CFG_BITS'(15);
        default: fcount = CFG_BITS'($urandom_range(0, 15));
      endcase
      set_frame_count(fcount);
      phase_len = $urandom_range(20, 80);
      steady    = ($urandom_range(0, 3) == 0);
      ws_size   = $urandom_range(1, 12);
      for (int i = 0; i < ws_size; i++)
        ws[i] = PAGE_BITS'($urandom_range(0, 255));
      for (int k = 0; k < phase_len; k++) begin
        if (!steady && burst_left == 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 24);
        end
        if ($urandom_range(0, 4) == 0)
          pg = PAGE_BITS'($urandom_range(0, 255));
        else
          pg = ws[$urandom_range(0, ws_size - 1)];
        drive_ref(pg);
        if (burst_left > 0)
          burst_left--;
      end
      n_random += phase_len;
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d of %0d page references over %0d frame-count writes,",
             checked, n_items, n_settings);
    $display("including a %0d-hit single-frame reuse run and duplicate residency.",
             SOAK_HITS);
    if (pending != 0)
      $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
